// ===== hdl/scmd_pkg.sv =====
// Shared constants, register codes and controller states of the stereo chorus.
`timescale 1ns / 1ps
`default_nettype none

package scmd_pkg;

  // Default build parameters
  localparam int DELAY_DEPTH_DEF   = 2048;
  localparam int SAMPLE_WIDTH_DEF  = 16;
  localparam int SINE_ENTRIES_DEF  = 1024;
  localparam int CHANNEL_COUNT_DEF = 2;

  // Field widths
  localparam int PHASE_W    = 24;
  localparam int DELAY_W    = 19;
  localparam int MIX_W      = 17;
  localparam int SINE_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int TAP_FRAC_W = 8;
  localparam int MIX_FRAC_W = 16;
  localparam int SCALE_W    = DELAY_W + SINE_W;
  // signed width of the modulated delay before clamping
  localparam int DCALC_W    = 26;

  localparam logic [MIX_W-1:0] MIX_ONE = MIX_W'(65536);

  // Register reset values
  localparam logic [PHASE_W-1:0] PHASE_INC_RST = PHASE_W'(350);
  localparam logic [DELAY_W-1:0] BASE_RST      = DELAY_W'(245760);
  localparam logic [DELAY_W-1:0] DEPTH_RST     = DELAY_W'(24576);
  localparam logic [MIX_W-1:0]   MIX_RST       = MIX_W'(32768);
  localparam logic [PHASE_W-1:0] ROFF_RST      = '0;
  localparam logic [DELAY_W-1:0] MIN_RST       = DELAY_W'(256);
  localparam logic [DELAY_W-1:0] MAX_RST       = DELAY_W'(523776);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_INC = 3'd0,
    CFG_BASE      = 3'd1,
    CFG_DEPTH     = 3'd2,
    CFG_MIX       = 3'd3,
    CFG_ROFF      = 3'd4,
    CFG_MIN       = 3'd5,
    CFG_MAX       = 3'd6
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PHASE,
    ST_SINE,
    ST_CLAMP,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_WET,
    ST_MIX,
    ST_OUT
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/scmd_ram.sv =====
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module scmd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// ===== hdl/scmd_sine_rom.sv =====
// Sine lookup table, Q1.15, built at elaboration, registered read.
`timescale 1ns / 1ps
`default_nettype none

module scmd_sine_rom #(
  parameter int SINE_ENTRIES = scmd_pkg::SINE_ENTRIES_DEF
) (
  input  wire logic                            clk,
  input  wire logic [$clog2(SINE_ENTRIES)-1:0] rd_addr,
  output logic signed [scmd_pkg::SINE_W-1:0]   rd_data
);
  import scmd_pkg::*;

  // odd polynomial coefficients of the quarter wave, Q2.30 scale
  localparam longint unsigned SIN_C1 = 64'd1686629713;
  localparam longint unsigned SIN_C3 = 64'd693598563;
  localparam longint unsigned SIN_C5 = 64'd85569278;
  localparam longint unsigned SIN_C7 = 64'd5026937;

  function automatic logic signed [SINE_W-1:0] sine_val(input int unsigned k);
    longint unsigned k4, q, rem, z, z2, a, b, c, s, r;
    logic signed [SINE_W-1:0] v;
    k4  = longint'(k) * 4;
    q   = k4 / SINE_ENTRIES;
    rem = k4 % SINE_ENTRIES;
    z   = (rem << 16) / SINE_ENTRIES;
    if (q[0]) begin
      z = 64'd65536 - z;
    end
    z2 = (z * z) >> 16;
    a  = SIN_C5 - ((z2 * SIN_C7) >> 16);
    b  = SIN_C3 - ((z2 * a) >> 16);
    c  = SIN_C1 - ((z2 * b) >> 16);
    s  = (z * c) >> 16;
    r  = (s + 64'd16384) >> 15;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    v = SINE_W'(r);
    return (q >= 2) ? -v : v;
  endfunction

  logic signed [SINE_W-1:0] rom_c [SINE_ENTRIES];

  for (genvar k = 0; k < SINE_ENTRIES; k++) begin : g_rom
    assign rom_c[k] = sine_val(k);
  end

  always_ff @(posedge clk) begin
    rd_data <= rom_c[rd_addr];
  end

endmodule

`default_nettype wire

// ===== hdl/stereo_chorus_modulated_delay_top.sv =====
// Stereo chorus: LFO-modulated, interpolated delay line per channel with dry/wet mix.
//
// Input channel: in_valid / in_stall carry one signed sample (in_audio_in) and its
// channel tag (in_channel_sel, 0 left, 1 right). Output channel: out_valid /
// out_stall carry one mixed sample (out_audio_out) for every request taken.
// Configuration: cfg_wr_en writes cfg_wr_data into the register cfg_index
// (increment, base, depth, mix, right offset, min, max); write only while idle.
//
// One request at a time: a request passes through the controller steps (accept,
// phase, sine lookup, scale, clamp, two delay-store reads, interpolate with
// write-back, mix, result); out_valid rises when the result step loads the output
// register, and a new sample is taken only in idle. The two reads share the one
// port of the delay-store RAM. The LFO phase steps after each right sample.
// Reset (synchronous, rst_n low) returns all registers to their defaults, the
// write pointers to zero and marks both delay lines empty; taps not yet written
// read as zero, so no clearing pass is needed and a request is taken at once.
// A stalled result stays in the output register; the next request is still
// accepted and finishes into it once the old one has been taken.
`timescale 1ns / 1ps
`default_nettype none

module stereo_chorus_modulated_delay_top #(
  parameter int DELAY_DEPTH   = scmd_pkg::DELAY_DEPTH_DEF,
  parameter int SAMPLE_WIDTH  = scmd_pkg::SAMPLE_WIDTH_DEF,
  parameter int SINE_ENTRIES  = scmd_pkg::SINE_ENTRIES_DEF,
  parameter int CHANNEL_COUNT = scmd_pkg::CHANNEL_COUNT_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [SAMPLE_WIDTH-1:0]      in_audio_in,
  input  wire logic                                in_channel_sel,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]           out_audio_out,
  input  wire logic                                cfg_wr_en,
  input  wire logic [scmd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [scmd_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);
  import scmd_pkg::*;

  localparam int SW     = SAMPLE_WIDTH;
  localparam int PTR_W  = $clog2(DELAY_DEPTH);
  localparam int BACK_W = $clog2(DELAY_DEPTH + 1);
  localparam int ADDR_W = $clog2(CHANNEL_COUNT * DELAY_DEPTH);
  localparam int SIDX_W = $clog2(SINE_ENTRIES);
  localparam int PPROD_W = PHASE_W + SIDX_W;

  // ---------------- configuration registers ----------------
  logic [PHASE_W-1:0] inc_r, roff_r;
  logic [DELAY_W-1:0] base_r, depth_r, min_r, max_r;
  logic [MIX_W-1:0]   mix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inc_r   <= PHASE_INC_RST;
      base_r  <= BASE_RST;
      depth_r <= DEPTH_RST;
      mix_r   <= MIX_RST;
      roff_r  <= ROFF_RST;
      min_r   <= MIN_RST;
      max_r   <= MAX_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_PHASE_INC: inc_r   <= cfg_wr_data[PHASE_W-1:0];
        CFG_BASE:      base_r  <= cfg_wr_data[DELAY_W-1:0];
        CFG_DEPTH:     depth_r <= cfg_wr_data[DELAY_W-1:0];
        CFG_MIX:       mix_r   <= cfg_wr_data[MIX_W-1:0];
        CFG_ROFF:      roff_r  <= cfg_wr_data[PHASE_W-1:0];
        CFG_MIN:       min_r   <= cfg_wr_data[DELAY_W-1:0];
        CFG_MAX:       max_r   <= cfg_wr_data[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- controller ----------------
  state_t state_r, state_nxt;
  logic   out_valid_r;
  logic   out_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_nxt = ST_PHASE;
        end
      end
      ST_PHASE: state_nxt = ST_SINE;
      ST_SINE:  state_nxt = ST_CLAMP;
      ST_CLAMP: state_nxt = ST_RD0;
      ST_RD0:   state_nxt = ST_RD1;
      ST_RD1:   state_nxt = ST_RD2;
      ST_RD2:   state_nxt = ST_WET;
      ST_WET:   state_nxt = ST_MIX;
      ST_MIX:   state_nxt = ST_OUT;
      ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------- LFO phase and pointers ----------------
  logic [PHASE_W-1:0] lfo_r;
  logic [PTR_W-1:0]   wp_r   [CHANNEL_COUNT];
  logic               full_r [CHANNEL_COUNT];
  logic               ch_r;
  logic [PTR_W-1:0]   wp_cur;
  logic               adv_phase;

  assign wp_cur    = wp_r[ch_r];
  assign adv_phase = (state_r == ST_PHASE) && (ch_r == 1'(CHANNEL_COUNT - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfo_r <= '0;
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
        wp_r[c]   <= '0;
        full_r[c] <= 1'b0;
      end
    end else begin
      if (adv_phase) begin
        lfo_r <= lfo_r + inc_r;
      end
      if (state_r == ST_WET) begin
        if (wp_cur == PTR_W'(DELAY_DEPTH - 1)) begin
          wp_r[ch_r]   <= '0;
          full_r[ch_r] <= 1'b1;
        end else begin
          wp_r[ch_r] <= wp_cur + PTR_W'(1);
        end
      end
    end
  end

  // ---------------- sine lookup ----------------
  logic [PHASE_W-1:0]       phase_c;
  logic [PPROD_W-1:0]       pprod_c;
  logic [SIDX_W-1:0]        sidx_c;
  logic signed [SINE_W-1:0] sine;

  assign phase_c = lfo_r + (ch_r ? roff_r : PHASE_W'(0));
  assign pprod_c = PPROD_W'(phase_c) * PPROD_W'(SINE_ENTRIES);
  assign sidx_c  = pprod_c[PHASE_W +: SIDX_W];

  scmd_sine_rom #(
    .SINE_ENTRIES (SINE_ENTRIES)
  ) u_sine (
    .clk     (clk),
    .rd_addr (sidx_c),
    .rd_data (sine)
  );

  // ---------------- delay computation ----------------
  logic [SCALE_W-1:0]        scale_r;
  logic [SINE_W-1:0]         sine_off;
  logic signed [DCALC_W-1:0] d0, d1, d2, d3, d4;
  logic [PTR_W-1:0]          i_r;
  logic [TAP_FRAC_W-1:0]     f_r;

  // sine + 32768 as unsigned
  assign sine_off = {~sine[SINE_W-1], sine[SINE_W-2:0]};

  always_comb begin
    d0 = $signed(DCALC_W'(base_r)) + $signed(DCALC_W'(scale_r[SCALE_W-1:15]))
         - $signed(DCALC_W'(depth_r));
    d1 = (d0 < $signed(DCALC_W'(min_r))) ? $signed(DCALC_W'(min_r)) : d0;
    d2 = (d1 > $signed(DCALC_W'(max_r))) ? $signed(DCALC_W'(max_r)) : d1;
    d3 = (d2 < $signed(DCALC_W'(256))) ? $signed(DCALC_W'(256)) : d2;
    d4 = (d3 > $signed(DCALC_W'((DELAY_DEPTH - 1) * 256)))
         ? $signed(DCALC_W'((DELAY_DEPTH - 1) * 256)) : d3;
  end

  // ---------------- delay store access ----------------
  logic [BACK_W-1:0] back_c;
  logic [BACK_W:0]   diff_c, pos_ext_c;
  logic [PTR_W-1:0]  pos_c, mem_pos_c;
  logic              tap_ok_c, tap_ok_r;
  logic [ADDR_W-1:0] ram_addr;
  logic              ram_we;
  logic [SW-1:0]     ram_rdata;
  logic signed [SW-1:0] tap_c;
  logic signed [SW-1:0] dry_r;

  assign back_c    = (state_r == ST_RD0) ? BACK_W'(i_r) : BACK_W'(i_r) + BACK_W'(1);
  assign diff_c    = (BACK_W + 1)'(wp_cur) - (BACK_W + 1)'(back_c);
  assign pos_ext_c = diff_c[BACK_W] ? diff_c + (BACK_W + 1)'(DELAY_DEPTH) : diff_c;
  assign pos_c     = pos_ext_c[PTR_W-1:0];
  // entries never written read as zero
  assign tap_ok_c  = full_r[ch_r] || (pos_c < wp_cur);

  assign ram_we    = (state_r == ST_WET);
  assign mem_pos_c = ram_we ? wp_cur : pos_c;
  assign ram_addr  = ADDR_W'(mem_pos_c) + (ch_r ? ADDR_W'(DELAY_DEPTH) : ADDR_W'(0));
  assign tap_c     = tap_ok_r ? $signed(ram_rdata) : SW'(0);

  scmd_ram #(
    .WIDTH (SW),
    .DEPTH (CHANNEL_COUNT * DELAY_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (dry_r),
    .rdata (ram_rdata)
  );

  // ---------------- interpolation and mix ----------------
  logic signed [SW-1:0]     x0_r, wet_r;
  logic signed [SW:0]       tdiff_c, mdiff_c, wet_sum_c;
  logic signed [SW+9:0]     tprod_r, tprod_sh;
  logic signed [SW+18:0]    mprod_r, mprod_sh;
  logic [MIX_W-1:0]         m_c;
  logic signed [SW+1:0]     res_c;
  logic signed [SW-1:0]     sat_c;

  assign tdiff_c   = {tap_c[SW-1], tap_c} - {x0_r[SW-1], x0_r};
  assign tprod_sh  = tprod_r >>> TAP_FRAC_W;
  assign wet_sum_c = {x0_r[SW-1], x0_r} + tprod_sh[SW:0];

  assign m_c      = (mix_r > MIX_ONE) ? MIX_ONE : mix_r;
  assign mdiff_c  = {wet_r[SW-1], wet_r} - {dry_r[SW-1], dry_r};
  assign mprod_sh = mprod_r >>> MIX_FRAC_W;
  assign res_c    = {{2{dry_r[SW-1]}}, dry_r} + mprod_sh[SW+1:0];

  always_comb begin
    if ((res_c[SW+1:SW-1] == '0) || (res_c[SW+1:SW-1] == '1)) begin
      sat_c = res_c[SW-1:0];
    end else if (res_c[SW+1]) begin
      sat_c = {1'b1, {(SW-1){1'b0}}};
    end else begin
      sat_c = {1'b0, {(SW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      dry_r <= in_audio_in;
      ch_r  <= (CHANNEL_COUNT == 2) ? in_channel_sel : 1'b0;
    end
    if (state_r == ST_SINE) begin
      scale_r <= SCALE_W'(depth_r) * SCALE_W'(sine_off);
    end
    if (state_r == ST_CLAMP) begin
      i_r <= d4[TAP_FRAC_W +: PTR_W];
      f_r <= d4[TAP_FRAC_W-1:0];
    end
    tap_ok_r <= tap_ok_c;
    if (state_r == ST_RD1) begin
      x0_r <= tap_c;
    end
    if (state_r == ST_RD2) begin
      tprod_r <= tdiff_c * $signed({1'b0, f_r});
    end
    if (state_r == ST_WET) begin
      wet_r <= wet_sum_c[SW-1:0];
    end
    if (state_r == ST_MIX) begin
      mprod_r <= mdiff_c * $signed({1'b0, m_c});
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_audio_out <= sat_c;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ===== hdl/scmd_chk.sv =====
// Port-level checker for the stereo chorus, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module scmd_chk #(
  parameter int SAMPLE_WIDTH = scmd_pkg::SAMPLE_WIDTH_DEF
) (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_stall,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic signed [SAMPLE_WIDTH-1:0] out_audio_out
);

  // after reset the block is empty and ready
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !in_stall && !out_valid)
    else $error("not idle after reset");

  // a request keeps the input closed while it is processed
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall ##1 in_stall)
    else $error("input reopened too early");

  // no result can appear in the cycle right after a request is taken
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !out_valid |=> !out_valid)
    else $error("result without processing time");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_audio_out))
    else $error("stalled result changed");

endmodule

bind stereo_chorus_modulated_delay_top scmd_chk #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_scmd_chk (.*);

`default_nettype wire
